// File: hdl/psgp_pkg.sv
package psgp_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_W     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORLD_H     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN_GAIN    = 3'd5;

	// Datapath widths.
	localparam int POS_W  = 20;   // positions
	localparam int OFS_W  = 21;   // listener-relative offset
	localparam int MAG_W  = 20;   // magnitude of an offset
	localparam int SIZE_W = 16;   // world size
	localparam int GAIN_W = 17;   // 16.16 gains
	localparam int PROD_W = MAG_W + GAIN_W;

	// Unity in 16.16.
	localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [GAIN_W-1:0] DIST_GAIN_RST = 17'd65;
	localparam logic [GAIN_W-1:0] PAN_GAIN_RST  = 17'd93;

	// Request into the shared remainder unit.
	typedef struct packed {
		logic              start;
		logic [MAG_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} rem_req_t;

	// Response from the shared remainder unit.
	typedef struct packed {
		logic              done;
		logic [SIZE_W-1:0] remainder;
	} rem_rsp_t;

endpackage

// File: hdl/psgp_ifs.sv
interface psgp_trig_if;
	logic               valid;
	logic               ready;
	logic [15:0]        sound_id;
	logic signed [19:0] source_x;
	logic signed [19:0] source_y;

	modport source (output valid, sound_id, source_x, source_y, input ready);
	modport sink (input valid, sound_id, source_x, source_y, output ready);
endinterface

interface psgp_play_if;
	logic               valid;
	logic               ready;
	logic [15:0]        patch_out;
	logic signed [17:0] pan_out;
	logic [16:0]        volume_out;
	logic [15:0]        play_tag;

	modport source (output valid, patch_out, pan_out, volume_out, play_tag, input ready);
	modport sink (input valid, patch_out, pan_out, volume_out, play_tag, output ready);
endinterface

interface psgp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/psgp_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
module psgp_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  psgp_pkg::rem_req_t  req,
	output psgp_pkg::rem_rsp_t  rsp
);

	localparam int CNT_W = $clog2(psgp_pkg::MAG_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [psgp_pkg::MAG_W-1:0]  dvd_q;
	logic [psgp_pkg::SIZE_W-1:0] div_q;
	logic [psgp_pkg::SIZE_W-1:0] rem_q;
	logic [psgp_pkg::SIZE_W:0]   trial;
	logic [psgp_pkg::SIZE_W:0]   trial_sub;

	assign trial     = {rem_q, dvd_q[psgp_pkg::MAG_W-1]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(psgp_pkg::MAG_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[psgp_pkg::MAG_W-2:0], 1'b0};
			// The partial remainder stays below the divisor, so 16 bits hold it.
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[psgp_pkg::SIZE_W-1:0];
			end else begin
				rem_q <= trial[psgp_pkg::SIZE_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// File: hdl/psgp_mul.sv
// Shared unsigned multiplier with a registered product.
module psgp_mul (
	input  logic                        clk,
	input  logic [psgp_pkg::MAG_W-1:0]  a,
	input  logic [psgp_pkg::GAIN_W-1:0] b,
	output logic [psgp_pkg::PROD_W-1:0] p
);

	logic [psgp_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {{psgp_pkg::GAIN_W{1'b0}}, a} * {{psgp_pkg::MAG_W{1'b0}}, b};
	end

	assign p = p_q;

endmodule

// File: hdl/positional_sound_gain_pan_unit.sv
// Positional sound gain and pan unit.
//
// A request on the trigger channel carries a sound id and a 2D source position.
// The block subtracts the listener position, folds each offset into the world
// when that axis has a nonzero wrap size, and scales the offsets by the
// distance gain. A source whose scaled distance reaches one on either axis is
// dropped silently and the play tag does not advance. Otherwise one request
// leaves on the play channel with the id, a clamped 16.16 pan, a 16.16 volume
// and a 16-bit wrapping play tag.
// Configuration is written through the cfg channel, which is always ready; a
// write to an index past the last register is ignored. Write only while idle.
// An accepted item passes, for each axis that wraps, through the shared remainder
// unit (start, 20 bit steps, answer) and the fold; an axis without wrapping
// skips the unit. Then five products go through the shared multiplier and the
// result register is loaded. The trigger channel is ready only between items,
// so a new item is taken only once the last one is loaded or dropped. If the
// receiver stalls, the next finished item waits and holds the sequencer until
// the output register frees. Reset clears the play tag, puts the listener at
// the origin, turns wrapping off and sets the gains to their defaults.
module positional_sound_gain_pan_unit (
	input logic         clk,
	input logic         arst_n,
	psgp_trig_if.sink   trigger,
	psgp_play_if.source play,
	psgp_cfg_if.sink    cfg
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FOLDX = 4'd1;
	localparam logic [3:0] S_WAITX = 4'd2;
	localparam logic [3:0] S_FOLDY = 4'd3;
	localparam logic [3:0] S_WAITY = 4'd4;
	localparam logic [3:0] S_MX    = 4'd5;
	localparam logic [3:0] S_MY    = 4'd6;
	localparam logic [3:0] S_MP    = 4'd7;
	localparam logic [3:0] S_MH    = 4'd8;
	localparam logic [3:0] S_MV    = 4'd9;
	localparam logic [3:0] S_MW    = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	localparam int OW = psgp_pkg::OFS_W;
	localparam int MW = psgp_pkg::MAG_W;
	localparam int SW = psgp_pkg::SIZE_W;
	localparam int GW = psgp_pkg::GAIN_W;
	localparam int PW = psgp_pkg::PROD_W;

	// Configuration registers.
	logic signed [psgp_pkg::POS_W-1:0] lx_q;
	logic signed [psgp_pkg::POS_W-1:0] ly_q;
	logic [SW-1:0]                     ww_q;
	logic [SW-1:0]                     wh_q;
	logic [GW-1:0]                     dg_q;
	logic [GW-1:0]                     pg_q;

	// Sequencer and working registers.
	logic [3:0]           state_q;
	logic [15:0]          id_q;
	logic signed [OW-1:0] dx_q;
	logic signed [OW-1:0] dy_q;
	logic                 oor_q;
	logic [15:0]          hx_q;
	logic [15:0]          hy_q;
	logic signed [17:0]   pan_q;
	logic [16:0]          vol_q;
	logic [15:0]          tag_q;

	// Output register.
	logic                 out_v_q;
	logic [15:0]          out_id_q;
	logic signed [17:0]   out_pan_q;
	logic [16:0]          out_vol_q;
	logic [15:0]          out_tag_q;

	logic                 in_acc;
	logic                 out_load;

	// Shared units.
	psgp_pkg::rem_req_t   rem_req;
	psgp_pkg::rem_rsp_t   rem_rsp;
	logic [MW-1:0]        mul_a;
	logic [GW-1:0]        mul_b;
	logic [PW-1:0]        prod;

	// Magnitudes of the current offsets.
	logic [OW-1:0]        dx_neg;
	logic [OW-1:0]        dy_neg;
	logic [MW-1:0]        mag_x;
	logic [MW-1:0]        mag_y;

	// Fold of the axis whose remainder is returning.
	logic                 fold_y;
	logic [SW-1:0]        fold_size;
	logic                 fold_neg;
	logic [SW-1:0]        fold_r0;
	logic [SW:0]          fold_d;
	logic [OW-1:0]        fold_ofs;

	// Product decoding.
	logic                 prod_oor;
	logic [16:0]          h_sub;
	logic [16:0]          pan_mag;
	logic [17:0]          pan_pos;

	psgp_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	psgp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign cfg.ready     = 1'b1;
	assign trigger.ready = (state_q == S_IDLE);
	assign in_acc        = trigger.valid && trigger.ready;
	assign out_load      = (state_q == S_EMIT) && (!out_v_q || play.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0;
			ly_q <= '0;
			ww_q <= '0;
			wh_q <= '0;
			dg_q <= psgp_pkg::DIST_GAIN_RST;
			pg_q <= psgp_pkg::PAN_GAIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				psgp_pkg::CFG_LISTENER_X: lx_q <= cfg.data;
				psgp_pkg::CFG_LISTENER_Y: ly_q <= cfg.data;
				psgp_pkg::CFG_WORLD_W:    ww_q <= cfg.data[SW-1:0];
				psgp_pkg::CFG_WORLD_H:    wh_q <= cfg.data[SW-1:0];
				psgp_pkg::CFG_DIST_GAIN:  dg_q <= cfg.data[GW-1:0];
				psgp_pkg::CFG_PAN_GAIN:   pg_q <= cfg.data[GW-1:0];
				default: ;
			endcase
		end
	end

	// The offsets span 21 bits, but their magnitude never exceeds 2^20 - 1.
	assign dx_neg = OW'(0) - dx_q;
	assign dy_neg = OW'(0) - dy_q;
	assign mag_x  = dx_q[OW-1] ? dx_neg[MW-1:0] : dx_q[MW-1:0];
	assign mag_y  = dy_q[OW-1] ? dy_neg[MW-1:0] : dy_q[MW-1:0];

	// Floored modulo from the remainder of the magnitude, then the fold into
	// the half-open range centered on the listener.
	always_comb begin
		fold_y    = (state_q == S_WAITY);
		fold_size = fold_y ? wh_q : ww_q;
		fold_neg  = fold_y ? dy_q[OW-1] : dx_q[OW-1];
		if (fold_neg && (rem_rsp.remainder != '0)) begin
			fold_r0 = fold_size - rem_rsp.remainder;
		end else begin
			fold_r0 = rem_rsp.remainder;
		end
		if (fold_r0 > (fold_size >> 1)) begin
			fold_d = {1'b0, fold_r0} - {1'b0, fold_size};
		end else begin
			fold_d = {1'b0, fold_r0};
		end
		fold_ofs = {{(OW-SW-1){fold_d[SW]}}, fold_d};
	end

	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = mag_x;
		rem_req.divisor  = ww_q;
		if (state_q == S_FOLDX) begin
			rem_req.start = (ww_q != '0);
		end else if (state_q == S_FOLDY) begin
			rem_req.start    = (wh_q != '0);
			rem_req.dividend = mag_y;
			rem_req.divisor  = wh_q;
		end
	end

	// Operand selection for the shared multiplier. Each product is read one
	// state after its operands are presented.
	always_comb begin
		case (state_q)
			S_MX: begin
				mul_a = mag_x;
				mul_b = dg_q;
			end
			S_MY: begin
				mul_a = mag_y;
				mul_b = dg_q;
			end
			S_MP: begin
				mul_a = mag_x;
				mul_b = pg_q;
			end
			S_MH: begin
				mul_a = {{(MW-16){1'b0}}, hx_q};
				mul_b = {{(GW-16){1'b0}}, hy_q};
			end
			S_MV: begin
				// Half of v = (hx * hy) >> 14, which is at most 2^15.
				mul_a = {{(MW-16){1'b0}}, prod[30:15]};
				mul_b = {{(GW-16){1'b0}}, prod[30:15]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// A scaled distance is out of range once it reaches one in 16.16.
	assign prod_oor = (prod[PW-1:16] != '0);
	assign h_sub    = psgp_pkg::ONE_Q16 - {1'b0, prod[15:0]};
	assign pan_mag  = (prod > PW'(psgp_pkg::ONE_Q16)) ? psgp_pkg::ONE_Q16 : prod[16:0];
	assign pan_pos  = {1'b0, pan_mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tag_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_FOLDX;
					end
				end
				S_FOLDX: state_q <= (ww_q != '0) ? S_WAITX : S_FOLDY;
				S_WAITX: begin
					if (rem_rsp.done) begin
						state_q <= S_FOLDY;
					end
				end
				S_FOLDY: state_q <= (wh_q != '0) ? S_WAITY : S_MX;
				S_WAITY: begin
					if (rem_rsp.done) begin
						state_q <= S_MX;
					end
				end
				S_MX: state_q <= S_MY;
				S_MY: state_q <= S_MP;
				S_MP: state_q <= (oor_q || prod_oor) ? S_IDLE : S_MH;
				S_MH: state_q <= S_MV;
				S_MV: state_q <= S_MW;
				S_MW: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_load) begin
						state_q <= S_IDLE;
						tag_q   <= tag_q + 16'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= trigger.sound_id;
			dx_q <= {trigger.source_x[19], trigger.source_x} - {lx_q[19], lx_q};
			dy_q <= {trigger.source_y[19], trigger.source_y} - {ly_q[19], ly_q};
		end
		if ((state_q == S_WAITX) && rem_rsp.done) begin
			dx_q <= fold_ofs;
		end
		if ((state_q == S_WAITY) && rem_rsp.done) begin
			dy_q <= fold_ofs;
		end
		if (state_q == S_MY) begin
			oor_q <= prod_oor;
			hx_q  <= h_sub[16:1];
		end
		if (state_q == S_MP) begin
			hy_q <= h_sub[16:1];
		end
		if (state_q == S_MH) begin
			pan_q <= dx_q[OW-1] ? (18'sd0 - pan_pos) : pan_pos;
		end
		if (state_q == S_MW) begin
			vol_q <= prod[30:14];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (play.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_id_q  <= id_q;
			out_pan_q <= pan_q;
			out_vol_q <= vol_q;
			out_tag_q <= tag_q;
		end
	end

	assign play.valid      = out_v_q;
	assign play.patch_out  = out_id_q;
	assign play.pan_out    = out_pan_q;
	assign play.volume_out = out_vol_q;
	assign play.play_tag   = out_tag_q;

`ifndef SYNTHESIS
	// An accepted trigger keeps the channel closed on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		trigger.valid && trigger.ready |=> !trigger.ready)
		else $error("trigger accepted again while an item is in work");

	// A loaded result carries the tag from before the advance.
	a_tag_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> play.valid && (play.play_tag == tag_q - 16'd1))
		else $error("play tag does not match the advanced counter");

	// Volume and pan stay within unity.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		play.valid |-> (play.volume_out <= 17'h10000) &&
			(play.pan_out <= 18'sh10000) && (play.pan_out >= -18'sh10000))
		else $error("result outside its 16.16 range");

	// The remainder unit only answers while the sequencer waits for it.
	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == S_WAITX) || (state_q == S_WAITY))
		else $error("remainder returned outside a fold");
`endif

endmodule
